// ----- rtl/core/b64dec_pkg.sv -----
`default_nettype none
package b64dec_pkg;

  localparam logic [7:0] CODE_BAD = 8'hFF;
  localparam logic [7:0] CODE_PAD = 8'hFE;

  localparam logic [11:0] MAX_BYTES_RESET = 12'd64;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One queued job: every result that a single character causes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_status;
    logic            err;
    logic [11:0]     base;
  } job_t;

  function automatic logic [7:0] sextet_of(input logic [7:0] ch);
    logic [7:0] code;
    code = CODE_BAD;
    if (ch inside {[8'h41:8'h5A]}) begin
      code = ch - 8'h41;
    end else if (ch inside {[8'h61:8'h7A]}) begin
      code = ch - 8'h61 + 8'd26;
    end else if (ch inside {[8'h30:8'h39]}) begin
      code = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      code = 8'd62;
    end else if (ch == 8'h2F) begin
      code = 8'd63;
    end else if (ch == 8'h3D) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b64dec_char_if.sv -----
`default_nettype none
interface b64dec_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       last_char;

  modport source (output valid, output in_char, output last_char, input ready);
  modport sink   (input valid, input in_char, input last_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/b64dec_res_if.sv -----
`default_nettype none
interface b64dec_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  logic        decode_error;
  logic [11:0] byte_count;
  logic        last_of_run;

  modport source (output valid, output out_byte, output is_status, output decode_error,
                  output byte_count, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_status, input decode_error,
                  input byte_count, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/b64dec_front.sv -----
`default_nettype none
module b64dec_front
  import b64dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  b64dec_char_if.sink      chars,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        q_full,
  output      logic        push,
  output      job_t        job
);

  logic [11:0] max_bytes;
  logic [17:0] sextets;
  logic [2:0]  pad_marks;
  logic [1:0]  pos;
  logic [11:0] bytes_emitted;
  logic        err;

  logic [17:0] sextets_next;
  logic [2:0]  pad_marks_next;
  logic [1:0]  pos_next;
  logic [11:0] bytes_emitted_next;
  logic        err_next;

  logic        accept;
  logic [7:0]  code;
  logic        is_bad;
  logic        is_pad;
  logic [5:0]  val;
  logic        pad2;
  logic [1:0]  cnt;
  logic [1:0]  n;
  logic [12:0] room1;
  logic [12:0] room2;
  logic [12:0] room3;
  logic        ok1;
  logic        ok2;
  logic        ok3;
  logic        err_a;
  logic        err_b;
  logic        err_c;
  logic        err_final;

  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;

  assign code   = sextet_of(chars.in_char);
  assign is_bad = (code == CODE_BAD);
  assign is_pad = (code == CODE_PAD);
  assign val    = (is_bad || is_pad) ? 6'd0 : code[5:0];
  assign pad2   = pad_marks[2];

  assign room1 = {1'b0, bytes_emitted} + 13'd1;
  assign room2 = {1'b0, bytes_emitted} + 13'd2;
  assign room3 = {1'b0, bytes_emitted} + 13'd3;
  assign ok1   = room1 <= {1'b0, max_bytes};
  assign ok2   = room2 <= {1'b0, max_bytes};
  assign ok3   = room3 <= {1'b0, max_bytes};

  always_comb begin
    sextets_next       = sextets;
    pad_marks_next     = pad_marks;
    pos_next           = pos;
    cnt                = 2'd0;
    n                  = 2'd0;
    err_a              = err || is_bad || (is_pad && (pos < 2'd2));
    err_b              = err_a;
    job.bytes[0]       = {sextets[17:12], sextets[11:10]};
    job.bytes[1]       = {sextets[9:6], sextets[5:2]};
    job.bytes[2]       = {sextets[1:0], val};
    if (pos != 2'd3) begin
      sextets_next = {sextets[11:0], val};
      if (is_pad) begin
        pad_marks_next = pad_marks | (3'd1 << pos);
      end
      pos_next = pos + 2'd1;
    end else begin
      err_b = err_a || (pad2 && !is_pad);
      cnt   = pad2 ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
      if (!err_b) begin
        // Bytes stop at the first one that would overrun the capacity.
        if (!ok1) begin
          n = 2'd0;
        end else if (cnt == 2'd1 || !ok2) begin
          n = 2'd1;
        end else if (cnt == 2'd2 || !ok3) begin
          n = 2'd2;
        end else begin
          n = 2'd3;
        end
      end
      sextets_next   = '0;
      pad_marks_next = '0;
      pos_next       = 2'd0;
    end
    err_c              = err_b || (!err_b && (n < cnt));
    err_final          = err_c || (pos_next != 2'd0);
    bytes_emitted_next = bytes_emitted + {10'd0, n};
    err_next           = err_c;
    if (chars.last_char) begin
      sextets_next       = '0;
      pad_marks_next     = '0;
      pos_next           = 2'd0;
      bytes_emitted_next = '0;
      err_next           = 1'b0;
    end
    job.nbytes     = n;
    job.has_status = chars.last_char;
    job.err        = err_final;
    job.base       = bytes_emitted;
  end

  assign push = accept && ((n != 2'd0) || chars.last_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes     <= MAX_BYTES_RESET;
      sextets       <= '0;
      pad_marks     <= '0;
      pos           <= '0;
      bytes_emitted <= '0;
      err           <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_bytes <= cfg_wdata;
      end
      if (accept) begin
        sextets       <= sextets_next;
        pad_marks     <= pad_marks_next;
        pos           <= pos_next;
        bytes_emitted <= bytes_emitted_next;
        err           <= err_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/b64dec_queue.sv -----
`default_nettype none
module b64dec_queue
  import b64dec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output      logic full,
  input  wire logic pop,
  output      logic head_valid,
  output      job_t head_job
);

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/b64dec_back.sv -----
`default_nettype none
module b64dec_back
  import b64dec_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire job_t   head_job,
  output      logic   pop,
  b64dec_res_if.source results
);

  logic [1:0]  idx;
  logic [2:0]  total;
  logic        is_last_res;
  logic        load;
  logic        is_byte;
  logic [7:0]  sel_byte;
  logic [11:0] sel_count;

  assign total       = {1'b0, head_job.nbytes} + {2'b0, head_job.has_status};
  assign is_last_res = ({1'b0, idx} + 3'd1) == total;
  assign load        = head_valid && (!results.valid || results.ready);
  assign pop         = load && is_last_res;
  assign is_byte     = idx < head_job.nbytes;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head_job.bytes[0];
      2'd1:    sel_byte = head_job.bytes[1];
      2'd2:    sel_byte = head_job.bytes[2];
      default: sel_byte = 8'd0;
    endcase
    if (is_byte) begin
      sel_count = head_job.base + {10'd0, idx} + 12'd1;
    end else begin
      sel_count = head_job.base + {10'd0, head_job.nbytes};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.out_byte     <= is_byte ? sel_byte : 8'd0;
      results.is_status    <= !is_byte;
      results.decode_error <= !is_byte && head_job.err;
      results.byte_count   <= sel_count;
      results.last_of_run  <= is_last_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      idx           <= '0;
    end else begin
      if (load) begin
        results.valid <= 1'b1;
        idx           <= is_last_res ? 2'd0 : idx + 2'd1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/base64_stream_decoder.sv -----
`default_nettype none
// Channel   Direction  Beat contents
// chars     in         in_char, last_char
// results   out        out_byte, is_status, decode_error, byte_count, last_of_run
// cfg       in         cfg_we, cfg_wdata (max_bytes)
//
// A character is taken every cycle while the four-entry job queue has room.
// The result side moves one beat per cycle out of its output register when
// results.ready allows; a character that completes a group yields up to four beats.
// Reset is synchronous; it sets max_bytes to 64 and empties the queue.
// A stall on results fills the queue and then holds chars.ready low.
module base64_stream_decoder
  import b64dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  b64dec_char_if.sink      chars,
  b64dec_res_if.source     results,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  b64dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  b64dec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .results    (results)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("job pushed into a full queue");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.is_status) |-> results.last_of_run)
    else $error("status beat not marked as last of run");

  a_error_only_in_status: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.decode_error) |-> results.is_status)
    else $error("error flag on a data beat");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.is_status) |-> (results.out_byte == 8'd0))
    else $error("status beat carries a nonzero byte");

  a_pop_only_with_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("queue popped while empty");

endmodule
`default_nettype wire
